// ===== sv/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape / UTF-8 check block.
// Used by the decoder and the top level. No dependencies.
package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [3:0] ERR_UNTERMINATED = 4'd0;
  localparam logic [3:0] ERR_END_AFTER_BS = 4'd1;
  localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd2;
  localparam logic [3:0] ERR_SHORT_U      = 4'd3;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
  localparam logic [3:0] ERR_LONE_HIGH    = 4'd5;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd6;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd7;
  localparam logic [3:0] ERR_CONTROL      = 4'd8;
  localparam logic [3:0] ERR_BAD_LEAD     = 4'd9;
  localparam logic [3:0] ERR_SHORT_UTF8   = 4'd10;
  localparam logic [3:0] ERR_BAD_CONT     = 4'd11;

  localparam int unsigned MaxData = 4;

  // Everything one input item releases: up to four data bytes, then an
  // optional end or error result.
  typedef struct packed {
    logic [2:0]            n_data;
    logic [MaxData-1:0][7:0] data;
    logic                  term;
    logic [1:0]            term_kind;
    logic [3:0]            term_code;
  } bundle_t;

endpackage

// ===== sv/jsu_in_if.sv =====
// Input channel: one raw string byte per item.
// Depends on nothing.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_req;

  modport source (output valid, output in_byte, output final_req, input ready);
  modport sink   (input valid, input in_byte, input final_req, output ready);
endinterface

// ===== sv/jsu_out_if.sv =====
// Output channel: one decoded byte, end or error result per item.
// Depends on nothing.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

// ===== sv/json_string_unescape_utf8_check.sv =====
// JSON string body decoder with UTF-8 validation. Raw bytes of a string body
// (after the opening quote) go in one per item; decoded UTF-8 bytes come out,
// followed by an end result on the closing quote or an error result on any
// fault, after which the decoder is back at its initial state. Rate: one
// input item per cycle, while the output is ready, whenever that item yields
// at most one result. An item that yields more (up to four data bytes plus
// an end or error) holds the input until all have left; the result register
// drains one result per cycle while the output is ready. The next item is
// taken in the cycle its last result leaves. Items that yield nothing never
// stall. No clearing pass after reset.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and jsu_decode.
module json_string_unescape_utf8_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  jsu_in_if.sink      in_i,
  jsu_out_if.source   out_o
);

  jsu_pkg::bundle_t bnd_d;   // results of the item being accepted
  jsu_pkg::bundle_t bnd_q;   // results still being handed out
  logic [2:0] rem_q, rem_d;  // results left in bnd_q
  logic [2:0] idx_q, idx_d;  // next result to show
  logic       take;
  logic       out_fire;
  logic       show_data;

  assign out_fire = out_o.valid && out_o.ready;

  // Free when empty, or when the last pending result leaves this cycle.
  assign in_i.ready = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_o.ready);
  assign take       = in_i.valid && in_i.ready;

  jsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .in_byte_i   (in_i.in_byte),
    .final_req_i (in_i.final_req),
    .bundle_o    (bnd_d)
  );

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (take) begin
      rem_d = bnd_d.n_data + {2'b00, bnd_d.term};
      idx_d = 3'd0;
    end else if (out_fire) begin
      rem_d = rem_q - 3'd1;
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      idx_q <= 3'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) bnd_q <= bnd_d;
  end

  // Data bytes first, the end or error result after them.
  assign show_data        = idx_q < bnd_q.n_data;
  assign out_o.valid      = rem_q != 3'd0;
  assign out_o.kind       = show_data ? jsu_pkg::KIND_DATA : bnd_q.term_kind;
  assign out_o.out_byte   = show_data ? bnd_q.data[idx_q[1:0]] : 8'h00;
  assign out_o.error_code = show_data ? jsu_pkg::ERR_UNTERMINATED : bnd_q.term_code;
  assign out_o.last       = !show_data;

endmodule

// ===== sv/jsu_decode.sv =====
// Decoder state and per-byte decode logic: escapes, \u, surrogates, UTF-8 checks.
// Depends on jsu_pkg.
module jsu_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       in_byte_i,
  input  logic             final_req_i,
  output jsu_pkg::bundle_t bundle_o
);

  localparam logic [3:0] PH_BODY   = 4'd0;
  localparam logic [3:0] PH_ESC    = 4'd1;
  localparam logic [3:0] PH_HEXHI  = 4'd2;
  localparam logic [3:0] PH_WANTBS = 4'd3;
  localparam logic [3:0] PH_WANTU  = 4'd4;
  localparam logic [3:0] PH_HEXLO  = 4'd5;
  localparam logic [3:0] PH_UTF2   = 4'd6;
  localparam logic [3:0] PH_UTF3   = 4'd7;
  localparam logic [3:0] PH_UTF4   = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [11:0] hex_acc_q, hex_acc_d;   // first three digits
  logic        hex_bad_q, hex_bad_d;
  logic [9:0]  high_q, high_d;         // high surrogate minus D800
  logic [1:0]  u8_rem_q, u8_rem_d;
  logic [23:0] u8_held_q, u8_held_d;
  logic        cont_bad_q, cont_bad_d;

  jsu_pkg::bundle_t bnd;

  // digit value in [3:0], bit 4 set for a non-hex byte
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) r = {1'b0, c[3:0]};
    else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

  // UTF-8 encode of a code point
  function automatic jsu_pkg::bundle_t encode(input logic [20:0] cp);
    jsu_pkg::bundle_t b;
    b = '0;
    if (cp <= 21'h7F) begin
      b.n_data  = 3'd1;
      b.data[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      b.n_data  = 3'd2;
      b.data[0] = {3'b110, cp[10:6]};
      b.data[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      b.n_data  = 3'd3;
      b.data[0] = {4'b1110, cp[15:12]};
      b.data[1] = {2'b10, cp[11:6]};
      b.data[2] = {2'b10, cp[5:0]};
    end else begin
      b.n_data  = 3'd4;
      b.data[0] = {5'b11110, cp[20:18]};
      b.data[1] = {2'b10, cp[17:12]};
      b.data[2] = {2'b10, cp[11:6]};
      b.data[3] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

  always_comb begin
    logic [4:0]  hv;
    logic        bad_n;
    logic [15:0] acc16;
    logic        cb_n;
    logic [1:0]  rem_n;
    logic        done;   // item finished back in the body: a final byte closes with error 0
    logic        err;
    logic [3:0]  code;

    phase_d    = phase_q;
    hex_cnt_d  = hex_cnt_q;
    hex_acc_d  = hex_acc_q;
    hex_bad_d  = hex_bad_q;
    high_d     = high_q;
    u8_rem_d   = u8_rem_q;
    u8_held_d  = u8_held_q;
    cont_bad_d = cont_bad_q;
    bnd        = '0;
    done       = 1'b0;
    err        = 1'b0;
    code       = jsu_pkg::ERR_UNTERMINATED;

    hv    = hex_val(in_byte_i);
    bad_n = hex_bad_q | hv[4];
    acc16 = {hex_acc_q, hv[3:0] & {4{~hv[4]}}};
    cb_n  = cont_bad_q | (in_byte_i[7:6] != 2'b10);
    rem_n = u8_rem_q - 2'd1;

    case (phase_q)
      PH_BODY: begin
        if (in_byte_i == 8'h22) begin
          bnd.term      = 1'b1;
          bnd.term_kind = jsu_pkg::KIND_END;
          phase_d       = PH_BODY;
        end else if (in_byte_i == 8'h5C) begin
          if (final_req_i) begin
            err = 1'b1; code = jsu_pkg::ERR_END_AFTER_BS;
          end else begin
            phase_d = PH_ESC;
          end
        end else if (in_byte_i < 8'h20) begin
          err = 1'b1; code = jsu_pkg::ERR_CONTROL;
        end else if (in_byte_i < 8'h80) begin
          bnd.n_data  = 3'd1;
          bnd.data[0] = in_byte_i;
          done        = 1'b1;
        end else if (in_byte_i[7:5] == 3'b110 || in_byte_i[7:4] == 4'b1110 ||
                     in_byte_i[7:3] == 5'b11110) begin
          if (final_req_i) begin
            err = 1'b1; code = jsu_pkg::ERR_SHORT_UTF8;
          end else begin
            u8_held_d  = {16'h0000, in_byte_i};
            cont_bad_d = 1'b0;
            if (!in_byte_i[5]) begin
              u8_rem_d = 2'd1; phase_d = PH_UTF2;
            end else if (!in_byte_i[4]) begin
              u8_rem_d = 2'd2; phase_d = PH_UTF3;
            end else begin
              u8_rem_d = 2'd3; phase_d = PH_UTF4;
            end
          end
        end else begin
          err = 1'b1; code = jsu_pkg::ERR_BAD_LEAD;
        end
      end
      PH_ESC: begin
        bnd.n_data = 3'd1;
        done       = 1'b1;
        case (in_byte_i)
          8'h22, 8'h5C, 8'h2F: bnd.data[0] = in_byte_i;
          8'h62:               bnd.data[0] = 8'h08;
          8'h66:               bnd.data[0] = 8'h0C;
          8'h6E:               bnd.data[0] = 8'h0A;
          8'h72:               bnd.data[0] = 8'h0D;
          8'h74:               bnd.data[0] = 8'h09;
          8'h75: begin
            bnd.n_data = 3'd0;
            done       = 1'b0;
            if (final_req_i) begin
              err = 1'b1; code = jsu_pkg::ERR_SHORT_U;
            end else begin
              phase_d   = PH_HEXHI;
              hex_cnt_d = 2'd0;
              hex_acc_d = '0;
              hex_bad_d = 1'b0;
            end
          end
          default: begin
            bnd.n_data = 3'd0;
            done       = 1'b0;
            err = 1'b1; code = jsu_pkg::ERR_BAD_ESCAPE;
          end
        endcase
        if (done) phase_d = PH_BODY;
      end
      PH_HEXHI, PH_HEXLO: begin
        if (hex_cnt_q != 2'd3) begin
          hex_cnt_d = hex_cnt_q + 2'd1;
          hex_acc_d = acc16[11:0];
          hex_bad_d = bad_n;
          if (final_req_i) begin
            err = 1'b1; code = jsu_pkg::ERR_SHORT_U;
          end
        end else if (bad_n) begin
          err = 1'b1; code = jsu_pkg::ERR_BAD_HEX;
        end else if (phase_q == PH_HEXHI) begin
          if (acc16 inside {[16'hD800:16'hDBFF]}) begin
            if (final_req_i) begin
              err = 1'b1; code = jsu_pkg::ERR_LONE_HIGH;
            end else begin
              high_d  = acc16[9:0];
              phase_d = PH_WANTBS;
            end
          end else if (acc16 inside {[16'hDC00:16'hDFFF]}) begin
            err = 1'b1; code = jsu_pkg::ERR_LONE_LOW;
          end else begin
            bnd     = encode({5'd0, acc16});
            done    = 1'b1;
            phase_d = PH_BODY;
          end
        end else begin
          if (!(acc16 inside {[16'hDC00:16'hDFFF]})) begin
            err = 1'b1; code = jsu_pkg::ERR_BAD_LOW;
          end else begin
            // 0x10000 + (high - D800) * 1024 + (low - DC00)
            bnd     = encode(21'h10000 + {1'b0, high_q, acc16[9:0]});
            done    = 1'b1;
            phase_d = PH_BODY;
          end
        end
      end
      PH_WANTBS: begin
        if (in_byte_i != 8'h5C || final_req_i) begin
          err = 1'b1; code = jsu_pkg::ERR_LONE_HIGH;
        end else begin
          phase_d = PH_WANTU;
        end
      end
      PH_WANTU: begin
        if (in_byte_i != 8'h75) begin
          err = 1'b1; code = jsu_pkg::ERR_LONE_HIGH;
        end else if (final_req_i) begin
          err = 1'b1; code = jsu_pkg::ERR_SHORT_U;
        end else begin
          phase_d   = PH_HEXLO;
          hex_cnt_d = 2'd0;
          hex_acc_d = '0;
          hex_bad_d = 1'b0;
        end
      end
      PH_UTF2, PH_UTF3, PH_UTF4: begin
        u8_held_d  = {u8_held_q[15:0], in_byte_i};
        cont_bad_d = cb_n;
        u8_rem_d   = rem_n;
        if (rem_n != 2'd0) begin
          if (final_req_i) begin
            err = 1'b1; code = jsu_pkg::ERR_SHORT_UTF8;
          end
        end else if (cb_n) begin
          err = 1'b1; code = jsu_pkg::ERR_BAD_CONT;
        end else begin
          done    = 1'b1;
          phase_d = PH_BODY;
          if (phase_q == PH_UTF2) begin
            bnd.n_data = 3'd2;
            bnd.data[0] = u8_held_q[7:0];
            bnd.data[1] = in_byte_i;
          end else if (phase_q == PH_UTF3) begin
            bnd.n_data = 3'd3;
            bnd.data[0] = u8_held_q[15:8];
            bnd.data[1] = u8_held_q[7:0];
            bnd.data[2] = in_byte_i;
          end else begin
            bnd.n_data = 3'd4;
            bnd.data[0] = u8_held_q[23:16];
            bnd.data[1] = u8_held_q[15:8];
            bnd.data[2] = u8_held_q[7:0];
            bnd.data[3] = in_byte_i;
          end
        end
      end
      default: begin
        phase_d = PH_BODY;
      end
    endcase

    if (err) begin
      bnd.term      = 1'b1;
      bnd.term_kind = jsu_pkg::KIND_ERROR;
      bnd.term_code = code;
      phase_d       = PH_BODY;
      hex_cnt_d     = 2'd0;
      hex_bad_d     = 1'b0;
      u8_rem_d      = 2'd0;
      cont_bad_d    = 1'b0;
    end else if (done && final_req_i) begin
      bnd.term      = 1'b1;
      bnd.term_kind = jsu_pkg::KIND_ERROR;
      bnd.term_code = jsu_pkg::ERR_UNTERMINATED;
      phase_d       = PH_BODY;
    end
  end

  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_BODY;
      hex_cnt_q  <= 2'd0;
      hex_bad_q  <= 1'b0;
      u8_rem_q   <= 2'd0;
      cont_bad_q <= 1'b0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      hex_cnt_q  <= hex_cnt_d;
      hex_bad_q  <= hex_bad_d;
      u8_rem_q   <= u8_rem_d;
      cont_bad_q <= cont_bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      hex_acc_q <= hex_acc_d;
      high_q    <= high_d;
      u8_held_q <= u8_held_d;
    end
  end

endmodule
